>>> sv/gtg_pkg.sv
`default_nettype none

package gtg_pkg;

    // Datapath widths
    localparam int GUARD_BITS = 8;
    localparam int XY_W       = 44;   // CORDIC x/y, 33-bit offset plus guard and growth
    localparam int ANGLE_W    = 34;   // Q29 radians
    localparam int DIFF_W     = 35;   // bearing minus yaw before wrapping
    localparam int ABS_W      = 31;   // |heading error|, Q29, never above pi
    localparam int DIST_W     = 34;   // distance, Q18.16
    localparam int MAG_W      = 24;   // heading error in degrees, Q8.16
    localparam int SPLIT_W    = 21;   // x is split in two halves for the gain product
    localparam int INV_W      = 20;
    localparam int PPROD_W    = SPLIT_W + INV_W;
    localparam int DSUM_W     = 63;
    localparam int RECIP_W    = 29;
    localparam int QPROD_W    = ABS_W + RECIP_W;
    localparam int NUM_W      = 55;
    localparam int LPROD_W    = DIST_W + 16;
    localparam int LRND_W     = LPROD_W - 12;
    localparam int TPROD_W    = MAG_W + 16;
    localparam int TRND_W     = TPROD_W - 12;
    localparam int MAX_STAGES = 32;

    // Angle constants, Q29 radians
    localparam logic signed [DIFF_W-1:0]  PI_Q29      = DIFF_W'(64'd1686629713);
    localparam logic signed [DIFF_W-1:0]  NEG_PI_Q29  = -DIFF_W'(64'd1686629713);
    localparam logic signed [DIFF_W-1:0]  TWO_PI_Q29  = DIFF_W'(64'd3373259426);
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q29 = ANGLE_W'(64'd843314857);

    // Inverse CORDIC gain, Q20
    localparam logic [INV_W-1:0]  INV_GAIN_Q20 = INV_W'(636751);
    localparam int                DIST_SHIFT   = 20 + GUARD_BITS;
    localparam logic [DSUM_W-1:0] DIST_ROUND   = DSUM_W'(64'd1) << (DIST_SHIFT - 1);

    // Radians to degrees: mag = round(|d| * 180 * 2^16 / pi_q29)
    localparam logic [NUM_W-1:0]   DEG_SCALE       = NUM_W'(64'd11796480);
    localparam logic [NUM_W-1:0]   DEG_HALF_PI     = NUM_W'(64'd843314856);
    localparam logic [NUM_W-1:0]   DEG_PI          = NUM_W'(64'd1686629713);
    localparam logic [RECIP_W-1:0] DEG_RECIP       = RECIP_W'(480631834);
    localparam int                 DEG_RECIP_SHIFT = 36;
    localparam logic [MAG_W-1:0]   DEG_MAX         = MAG_W'(11796480);

    localparam int Q12_ROUND = 2048;

    typedef enum logic [2:0] {
        CFG_HEADING_GAIN     = 3'd0,
        CFG_DISTANCE_GAIN    = 3'd1,
        CFG_HEADING_DEADBAND = 3'd2,
        CFG_ARRIVE_DISTANCE  = 3'd3,
        CFG_MAX_LINEAR_SPEED = 3'd4,
        CFG_MAX_TURN_RATE    = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [ANGLE_W-1:0] z;
        logic signed [15:0]        yaw;
        logic                      on_target;
    } t_cordic_item;

    // atan(2^-i) in Q29, rounded from a Q60 series
    function automatic logic signed [ANGLE_W-1:0] atan_q29(input int unsigned idx);
        logic signed [ANGLE_W-1:0] v;
        case (idx)
            0:       v = ANGLE_W'(421657428);
            1:       v = ANGLE_W'(248918915);
            2:       v = ANGLE_W'(131521918);
            3:       v = ANGLE_W'(66762579);
            4:       v = ANGLE_W'(33510843);
            5:       v = ANGLE_W'(16771758);
            6:       v = ANGLE_W'(8387925);
            7:       v = ANGLE_W'(4194219);
            8:       v = ANGLE_W'(2097141);
            9:       v = ANGLE_W'(1048575);
            30:      v = ANGLE_W'(1);
            31:      v = ANGLE_W'(0);
            default: v = ANGLE_W'(64'd1 << (29 - idx));
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/gtg_cordic.sv
`default_nettype none

module gtg_cordic #(
    parameter int STAGES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  gtg_pkg::t_cordic_item i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output gtg_pkg::t_cordic_item o_item,
    input  logic                  i_ready
);
    import gtg_pkg::*;

    t_cordic_item      r_item [STAGES];
    t_cordic_item      n_item [STAGES];
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] src_vld;
    logic [STAGES-1:0] adv;

    // A stage advances when it is empty or the next one advances
    genvar g;
    for (g = 0; g < STAGES; g++) begin : g_adv
        if (g == STAGES - 1) begin : g_last
            assign adv[g] = ~r_vld[g] | i_ready;
        end else begin : g_mid
            assign adv[g] = ~r_vld[g] | adv[g+1];
        end
    end

    // One micro-rotation per stage, shift amount fixed by the stage
    always_comb begin : c_rotate
        t_cordic_item              src;
        logic signed [XY_W-1:0]    sx;
        logic signed [XY_W-1:0]    sy;
        logic signed [ANGLE_W-1:0] sz;
        logic signed [XY_W-1:0]    xs;
        logic signed [XY_W-1:0]    ys;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                src        = i_item;
                src_vld[k] = i_valid;
            end else begin
                src        = r_item[k-1];
                src_vld[k] = r_vld[k-1];
            end
            sx = src.x;
            sy = src.y;
            sz = src.z;
            xs = sx >>> k;
            ys = sy >>> k;
            n_item[k] = src;
            if (!sy[XY_W-1]) begin
                n_item[k].x = sx + ys;
                n_item[k].y = sy - xs;
                n_item[k].z = sz + atan_q29(k);
            end else begin
                n_item[k].x = sx - ys;
                n_item[k].y = sy + xs;
                n_item[k].z = sz - atan_q29(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= src_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (adv[k] && src_vld[k]) begin
                r_item[k] <= n_item[k];
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_item  = r_item[STAGES-1];

endmodule

`default_nettype wire

>>> sv/go_to_goal_velocity_controller_unit.sv
`default_nettype none

// Go-to-goal velocity controller. Each item carries the robot pose (x, y in
// Q15.16 metres, yaw in Q2.13 radians) and a target point; each item gives one
// result: a forward speed and a turn rate, both Q8.16. A CORDIC vectoring
// pipeline turns the offset to the target into distance and bearing; the
// bearing minus yaw is wrapped into -pi..pi, converted to degrees, and each
// command is gain times error, zeroed inside its deadband (a value equal to
// the threshold counts as inside) and clamped, the turn rate keeping its sign.
// Target on the robot gives bearing zero and distance zero.
// Throughput is one item per clock while the output is not stalled. The path
// holds CORDIC_STAGES + 8 register stages: one pre-rotation stage, one stage
// per CORDIC rotation and seven post stages for the gain products, angle wrap
// and the reciprocal-multiply conversion to degrees. Every stage holds its own
// valid bit and fills bubbles while the output is stalled, so the input stays
// ready until every stage is full.
// Registers on the write port (index: name, format, reset): 0 heading_gain
// Q4.12 [2048], 1 distance_gain Q4.12 [2048], 2 heading_deadband Q8.16 deg
// [6554], 3 arrive_distance Q15.16 m [6554], 4 max_linear_speed Q8.16
// [65536], 5 max_turn_rate Q8.16 [65536]. Other indexes are ignored. Write
// them only while no item is in flight.

module go_to_goal_velocity_controller_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_current_x,
    input  logic signed [31:0] i_current_y,
    input  logic signed [15:0] i_current_yaw,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [23:0]        o_linear_speed,
    output logic signed [24:0] o_turn_rate
);
    import gtg_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_heading_gain;
    logic [15:0] r_distance_gain;
    logic [23:0] r_heading_deadband;
    logic [30:0] r_arrive_distance;
    logic [23:0] r_max_linear_speed;
    logic [23:0] r_max_turn_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading_gain     <= 16'd2048;
            r_distance_gain    <= 16'd2048;
            r_heading_deadband <= 24'd6554;
            r_arrive_distance  <= 31'd6554;
            r_max_linear_speed <= 24'd65536;
            r_max_turn_rate    <= 24'd65536;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_HEADING_GAIN:     r_heading_gain     <= i_cfg_data[15:0];
                CFG_DISTANCE_GAIN:    r_distance_gain    <= i_cfg_data[15:0];
                CFG_HEADING_DEADBAND: r_heading_deadband <= i_cfg_data[23:0];
                CFG_ARRIVE_DISTANCE:  r_arrive_distance  <= i_cfg_data;
                CFG_MAX_LINEAR_SPEED: r_max_linear_speed <= i_cfg_data[23:0];
                CFG_MAX_TURN_RATE:    r_max_turn_rate    <= i_cfg_data[23:0];
                default: ; // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pre-rotation: form the offset and fold it into the right half-plane
    // ------------------------------------------------------------------
    t_cordic_item r_pre;
    t_cordic_item n_pre;
    logic         r_pre_vld;
    logic         pre_adv;
    logic         cor_ready;

    always_comb begin : c_pre
        logic signed [32:0]     dx;
        logic signed [32:0]     dy;
        logic signed [XY_W-1:0] dxw;
        logic signed [XY_W-1:0] dyw;
        dx  = 33'(i_target_x) - 33'(i_current_x);
        dy  = 33'(i_target_y) - 33'(i_current_y);
        dxw = XY_W'(dx) <<< GUARD_BITS;
        dyw = XY_W'(dy) <<< GUARD_BITS;
        n_pre.yaw       = i_current_yaw;
        n_pre.on_target = (dx == '0) && (dy == '0);
        if (!dx[32]) begin
            n_pre.x = dxw;
            n_pre.y = dyw;
            n_pre.z = '0;
        end else if (!dy[32]) begin
            // second quadrant: rotate by -pi/2
            n_pre.x = dyw;
            n_pre.y = -dxw;
            n_pre.z = HALF_PI_Q29;
        end else begin
            // third quadrant: rotate by +pi/2
            n_pre.x = -dyw;
            n_pre.y = dxw;
            n_pre.z = -HALF_PI_Q29;
        end
    end

    assign pre_adv    = ~r_pre_vld | cor_ready;
    assign o_in_ready = pre_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld <= 1'b0;
        end else if (pre_adv) begin
            r_pre_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pre_adv && i_in_valid) begin
            r_pre <= n_pre;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring pipeline
    // ------------------------------------------------------------------
    logic         cor_valid;
    t_cordic_item cor_item;
    logic [7:1]   post_adv;
    logic [7:1]   r_post_vld;
    logic [7:1]   post_src_vld;

    gtg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pre_vld),
        .i_item  (r_pre),
        .o_ready (cor_ready),
        .o_valid (cor_valid),
        .o_item  (cor_item),
        .i_ready (post_adv[1])
    );

    // ------------------------------------------------------------------
    // Post stages: handshake chain
    // ------------------------------------------------------------------
    assign post_adv[7]     = ~r_post_vld[7] | i_out_ready;
    assign post_src_vld[1] = cor_valid;
    genvar g;
    for (g = 1; g < 7; g++) begin : g_post_adv
        assign post_adv[g]       = ~r_post_vld[g] | post_adv[g+1];
        assign post_src_vld[g+1] = r_post_vld[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post_vld <= '0;
        end else begin
            for (int k = 1; k <= 7; k++) begin
                if (post_adv[k]) begin
                    r_post_vld[k] <= post_src_vld[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // P1: heading difference, distance gain partial products
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] r_p1_draw;
    logic [PPROD_W-1:0]       r_p1_ph;
    logic [PPROD_W-1:0]       r_p1_pl;
    logic signed [DIFF_W-1:0] n_p1_draw;
    logic [PPROD_W-1:0]       n_p1_ph;
    logic [PPROD_W-1:0]       n_p1_pl;

    always_comb begin : c_p1
        logic signed [ANGLE_W-1:0] bearing;
        logic signed [31:0]        yaw_q29;
        logic [SPLIT_W-1:0]        xh;
        logic [SPLIT_W-1:0]        xl;
        bearing   = cor_item.on_target ? '0 : cor_item.z;
        yaw_q29   = {cor_item.yaw, 16'b0};
        n_p1_draw = DIFF_W'(bearing) - DIFF_W'(yaw_q29);
        // x is non-negative after vectoring and below 2^42
        xh        = cor_item.x[2*SPLIT_W-1:SPLIT_W];
        xl        = cor_item.x[SPLIT_W-1:0];
        n_p1_ph   = PPROD_W'(xh) * PPROD_W'(INV_GAIN_Q20);
        n_p1_pl   = PPROD_W'(xl) * PPROD_W'(INV_GAIN_Q20);
    end

    always_ff @(posedge i_clk) begin
        if (post_adv[1] && post_src_vld[1]) begin
            r_p1_draw <= n_p1_draw;
            r_p1_ph   <= n_p1_ph;
            r_p1_pl   <= n_p1_pl;
        end
    end

    // ------------------------------------------------------------------
    // P2: wrap into -pi..pi, take magnitude; finish the distance
    // ------------------------------------------------------------------
    logic             r_p2_neg;
    logic [ABS_W-1:0] r_p2_absd;
    logic [DIST_W-1:0] r_p2_dist;
    logic             n_p2_neg;
    logic [ABS_W-1:0] n_p2_absd;
    logic [DIST_W-1:0] n_p2_dist;

    always_comb begin : c_p2
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] dabs;
        logic [DSUM_W-1:0]        dsum;
        if (r_p1_draw > PI_Q29) begin
            d = r_p1_draw - TWO_PI_Q29;
        end else if (r_p1_draw < NEG_PI_Q29) begin
            d = r_p1_draw + TWO_PI_Q29;
        end else begin
            d = r_p1_draw;
        end
        n_p2_neg  = d[DIFF_W-1];
        dabs      = n_p2_neg ? -d : d;
        n_p2_absd = dabs[ABS_W-1:0];
        dsum      = (DSUM_W'(r_p1_ph) << SPLIT_W) + DSUM_W'(r_p1_pl) + DIST_ROUND;
        n_p2_dist = dsum[DIST_SHIFT +: DIST_W];
    end

    always_ff @(posedge i_clk) begin
        if (post_adv[2] && post_src_vld[2]) begin
            r_p2_neg  <= n_p2_neg;
            r_p2_absd <= n_p2_absd;
            r_p2_dist <= n_p2_dist;
        end
    end

    // ------------------------------------------------------------------
    // P3: reciprocal estimate of degrees; linear gain product
    // ------------------------------------------------------------------
    logic               r_p3_neg;
    logic [ABS_W-1:0]   r_p3_absd;
    logic [QPROD_W-1:0] r_p3_qprod;
    logic               r_p3_lin_en;
    logic [LPROD_W-1:0] r_p3_lin_prod;

    always_ff @(posedge i_clk) begin
        if (post_adv[3] && post_src_vld[3]) begin
            r_p3_neg      <= r_p2_neg;
            r_p3_absd     <= r_p2_absd;
            r_p3_qprod    <= QPROD_W'(r_p2_absd) * QPROD_W'(DEG_RECIP);
            r_p3_lin_en   <= r_p2_dist > DIST_W'(r_arrive_distance);
            r_p3_lin_prod <= LPROD_W'(r_p2_dist) * LPROD_W'(r_distance_gain);
        end
    end

    // ------------------------------------------------------------------
    // P4: back-multiply the estimate; round and clamp linear speed
    // ------------------------------------------------------------------
    logic             r_p4_neg;
    logic [MAG_W-1:0] r_p4_q0;
    logic [NUM_W-1:0] r_p4_qp;
    logic [NUM_W-1:0] r_p4_num;
    logic [23:0]      r_p4_lin;
    logic [MAG_W-1:0] n_p4_q0;
    logic [23:0]      n_p4_lin;

    always_comb begin : c_p4
        logic [LPROD_W-1:0] lsum;
        logic [LRND_W-1:0]  lrnd;
        n_p4_q0 = r_p3_qprod[DEG_RECIP_SHIFT +: MAG_W];
        lsum    = r_p3_lin_prod + LPROD_W'(Q12_ROUND);
        lrnd    = lsum[LPROD_W-1:12];
        if (!r_p3_lin_en) begin
            n_p4_lin = '0;
        end else if (lrnd > LRND_W'(r_max_linear_speed)) begin
            n_p4_lin = r_max_linear_speed;
        end else begin
            n_p4_lin = lrnd[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (post_adv[4] && post_src_vld[4]) begin
            r_p4_neg <= r_p3_neg;
            r_p4_q0  <= n_p4_q0;
            r_p4_qp  <= NUM_W'(n_p4_q0) * DEG_PI;
            r_p4_num <= NUM_W'(r_p3_absd) * DEG_SCALE + DEG_HALF_PI;
            r_p4_lin <= n_p4_lin;
        end
    end

    // ------------------------------------------------------------------
    // P5: correct the quotient by one where the remainder allows
    // ------------------------------------------------------------------
    logic             r_p5_neg;
    logic [MAG_W-1:0] r_p5_mag;
    logic [23:0]      r_p5_lin;
    logic [NUM_W-1:0] p5_rem;

    assign p5_rem = r_p4_num - r_p4_qp;

    always_ff @(posedge i_clk) begin
        if (post_adv[5] && post_src_vld[5]) begin
            r_p5_neg <= r_p4_neg;
            r_p5_mag <= (p5_rem >= DEG_PI) ? r_p4_q0 + MAG_W'(1) : r_p4_q0;
            r_p5_lin <= r_p4_lin;
        end
    end

    // ------------------------------------------------------------------
    // P6: deadband and turn gain product
    // ------------------------------------------------------------------
    logic               r_p6_neg;
    logic               r_p6_turn_en;
    logic [TPROD_W-1:0] r_p6_turn_prod;
    logic [23:0]        r_p6_lin;

    always_ff @(posedge i_clk) begin
        if (post_adv[6] && post_src_vld[6]) begin
            r_p6_neg       <= r_p5_neg;
            r_p6_turn_en   <= r_p5_mag > r_heading_deadband;
            r_p6_turn_prod <= TPROD_W'(r_p5_mag) * TPROD_W'(r_heading_gain);
            r_p6_lin       <= r_p5_lin;
        end
    end

    // ------------------------------------------------------------------
    // P7: round, clamp magnitude, restore sign; output register
    // ------------------------------------------------------------------
    logic [23:0]        r_p7_lin;
    logic signed [24:0] r_p7_turn;
    logic signed [24:0] n_p7_turn;

    always_comb begin : c_p7
        logic [TPROD_W-1:0] tsum;
        logic [TRND_W-1:0]  trnd;
        logic [23:0]        tmag;
        tsum = r_p6_turn_prod + TPROD_W'(Q12_ROUND);
        trnd = tsum[TPROD_W-1:12];
        if (!r_p6_turn_en) begin
            tmag = '0;
        end else if (trnd > TRND_W'(r_max_turn_rate)) begin
            tmag = r_max_turn_rate;
        end else begin
            tmag = trnd[23:0];
        end
        n_p7_turn = r_p6_neg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    end

    always_ff @(posedge i_clk) begin
        if (post_adv[7] && post_src_vld[7]) begin
            r_p7_lin  <= r_p6_lin;
            r_p7_turn <= n_p7_turn;
        end
    end

    assign o_out_valid    = r_post_vld[7];
    assign o_linear_speed = r_p7_lin;
    assign o_turn_rate    = r_p7_turn;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic [24:0] turn_abs;
    assign turn_abs = r_p7_turn[24] ? 25'(-r_p7_turn) : 25'(r_p7_turn);

    // Input back-pressure only when every stage is full and the output stalls
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while the pipeline has room");

    // Corrected quotient never exceeds 180 degrees
    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_post_vld[5] |-> (r_p5_mag <= DEG_MAX))
        else $error("heading error above 180 degrees");

    a_turn_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (post_adv[7] && post_src_vld[7]) |=> (turn_abs <= 25'($past(r_max_turn_rate))))
        else $error("turn rate outside its clamp");

    a_lin_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (post_adv[7] && post_src_vld[7]) |=> (r_p7_lin <= $past(r_max_linear_speed)))
        else $error("linear speed above its clamp");

endmodule

`default_nettype wire
